// File: hw/rtl/salc_pkg.sv
// ============================================================================
// salc_pkg: shared types and constants of the set-associative LRU lookup unit
// Row layout of the tag store, scan unit handshake types and sequencer states.
// ============================================================================
package salc_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = MAX_SET_BITS;
    localparam int WAY_W    = 3;
    localparam int RANK_W   = 3;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int ADDR_W   = 64;
    localparam int TAG_W    = 64;
    localparam int CNT_W    = 32;
    localparam int KIND_W   = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SB_W       = 3;
    localparam int OB_W       = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS    = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_WAYS_IN_USE = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_IFETCH = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_STORE  = 2'd2,
        KIND_MODIFY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    typedef logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_vec_t;
    typedef logic [MAX_WAYS-1:0][RANK_W-1:0] rank_vec_t;

    // One row of the tag store holds every way of one set.
    typedef struct packed {
        tag_vec_t            tag;
        logic [MAX_WAYS-1:0] valid;
        rank_vec_t           rank;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic start;
        logic step;
    } scan_ctl_t;

    typedef struct packed {
        logic              hit;
        logic [WAY_W-1:0]  hit_way;
        logic              free_found;
        logic [WAY_W-1:0]  free_way;
        logic [RANK_W-1:0] oldest_rank;
        logic [WAY_W-1:0]  oldest_way;
    } scan_res_t;

endpackage

// File: hw/rtl/salc_if.sv
// ============================================================================
// salc channel interfaces
// Request channel (kind, address) and result channel of the lookup unit.
// ============================================================================
interface salc_req_if;
    logic                        valid;
    logic                        ready;
    logic [salc_pkg::KIND_W-1:0] kind;
    logic [salc_pkg::ADDR_W-1:0] address;

    modport source (output valid, output kind, output address, input ready);
    modport sink   (input valid, input kind, input address, output ready);
endinterface

interface salc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       was_hit;
    logic                       was_eviction;
    logic [salc_pkg::WAY_W-1:0] way_used;
    logic [salc_pkg::CNT_W-1:0] hit_total;
    logic [salc_pkg::CNT_W-1:0] miss_total;
    logic [salc_pkg::CNT_W-1:0] eviction_total;
    logic                       last;

    modport source (output valid, output was_hit, output was_eviction, output way_used,
                    output hit_total, output miss_total, output eviction_total,
                    output last, input ready);
    modport sink   (input valid, input was_hit, input was_eviction, input way_used,
                    input hit_total, input miss_total, input eviction_total,
                    input last, output ready);
endinterface

// File: hw/rtl/set_assoc_lru_cache_lookup_unit.sv
// ============================================================================
// set_assoc_lru_cache_lookup_unit: tag and LRU replacement logic of a cache
// Splits each non-fetch address into tag and set, looks it up and updates tags,
// valid flags, LRU ranks and the saturating hit, miss and eviction counters.
// ============================================================================
// A lookup runs from acceptance through one tag store read, a scan of k ways
// (1 up to ways_in_use), one way per cycle through the single tag comparator,
// and one row write-back, which holds until the result register is free.
// The unit takes a new request only in idle, after the write-back; a modify runs
// two lookups and an instruction fetch runs none and gives no result. A waiting
// result holds the write-back and the unit; reset empties every set at once.
module set_assoc_lru_cache_lookup_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    salc_req_if.sink                            req,
    salc_rsp_if.source                          rsp
);

    // Configuration
    logic [salc_pkg::SB_W-1:0]   set_bits_reg;
    logic [salc_pkg::OB_W-1:0]   offset_bits_reg;
    logic [salc_pkg::WCNT_W-1:0] ways_in_use_reg;

    // Sequencer
    salc_pkg::state_t state_reg;
    salc_pkg::state_t state_next;
    salc_pkg::kind_t  kind_reg;
    logic             second_reg;
    logic             accept;
    logic             upd_fire;
    logic             out_free;
    logic             ram_re;
    salc_pkg::scan_ctl_t scan_ctl;

    // Request split
    logic [salc_pkg::SB_W-1:0]   sb_eff;
    logic [salc_pkg::OB_W:0]     tag_shift;
    logic [salc_pkg::ADDR_W-1:0] addr_shifted;
    logic [salc_pkg::SET_W-1:0]  set_mask;
    logic [salc_pkg::TAG_W-1:0]  tag_reg;
    logic [salc_pkg::SET_W-1:0]  set_reg;

    // Tag store
    logic [salc_pkg::NUM_SETS-1:0] row_ok_reg;
    logic [salc_pkg::ROW_W-1:0]    ram_rdata;
    salc_pkg::row_t                row_raw;
    salc_pkg::row_t                row_eff;
    salc_pkg::row_t                row_new;

    // Scan and update
    logic                          scan_done;
    salc_pkg::scan_res_t           scan_res;
    logic [salc_pkg::WCNT_W-1:0]   ways_eff;
    logic [salc_pkg::WAY_W-1:0]    last_idx;
    logic                          is_fill;
    logic                          is_evict;
    logic [salc_pkg::WAY_W-1:0]    way_sel;
    logic [salc_pkg::RANK_W:0]     old_rank;
    logic [salc_pkg::MAX_WAYS-1:0] valid_new;
    salc_pkg::rank_vec_t           ranks_new;

    // Counters and result register
    logic [salc_pkg::CNT_W-1:0] hits_reg;
    logic [salc_pkg::CNT_W-1:0] misses_reg;
    logic [salc_pkg::CNT_W-1:0] evictions_reg;
    logic [salc_pkg::CNT_W-1:0] hits_next;
    logic [salc_pkg::CNT_W-1:0] misses_next;
    logic [salc_pkg::CNT_W-1:0] evictions_next;
    logic                       out_valid_reg;
    logic                       out_hit_reg;
    logic                       out_evict_reg;
    logic [salc_pkg::WAY_W-1:0] out_way_reg;
    logic                       out_last_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= '0;
            offset_bits_reg <= '0;
            ways_in_use_reg <= salc_pkg::WCNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (salc_pkg::cfg_index_t'(cfg_index))
                salc_pkg::CFG_SET_BITS:    set_bits_reg    <= cfg_wdata[salc_pkg::SB_W-1:0];
                salc_pkg::CFG_OFFSET_BITS: offset_bits_reg <= cfg_wdata[salc_pkg::OB_W-1:0];
                salc_pkg::CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_wdata[salc_pkg::WCNT_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        if (set_bits_reg > salc_pkg::SB_W'(salc_pkg::MAX_SET_BITS))
        begin
            sb_eff = salc_pkg::SB_W'(salc_pkg::MAX_SET_BITS);
        end
        else
        begin
            sb_eff = set_bits_reg;
        end
        if (ways_in_use_reg == '0)
        begin
            ways_eff = salc_pkg::WCNT_W'(1);
        end
        else if (ways_in_use_reg > salc_pkg::WCNT_W'(salc_pkg::MAX_WAYS))
        begin
            ways_eff = salc_pkg::WCNT_W'(salc_pkg::MAX_WAYS);
        end
        else
        begin
            ways_eff = ways_in_use_reg;
        end
    end

    assign last_idx = salc_pkg::WAY_W'(ways_eff - 1'b1);

    // ---------------- address split ----------------
    assign tag_shift    = {1'b0, offset_bits_reg} + (salc_pkg::OB_W + 1)'(sb_eff);
    assign addr_shifted = req.address >> offset_bits_reg;
    assign set_mask     = ~({salc_pkg::SET_W{1'b1}} << sb_eff);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= salc_pkg::kind_t'(req.kind);
            set_reg  <= addr_shifted[salc_pkg::SET_W-1:0] & set_mask;
            // Shifting out the whole address leaves a zero tag.
            if (tag_shift[salc_pkg::OB_W])
            begin
                tag_reg <= '0;
            end
            else
            begin
                tag_reg <= req.address >> tag_shift[salc_pkg::OB_W-1:0];
            end
        end
    end

    // ---------------- sequencer ----------------
    assign out_free = !out_valid_reg || rsp.ready;
    assign accept   = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            salc_pkg::ST_IDLE:
            begin
                if (accept && (salc_pkg::kind_t'(req.kind) != salc_pkg::KIND_IFETCH))
                begin
                    state_next = salc_pkg::ST_READ;
                end
            end
            salc_pkg::ST_READ:
            begin
                state_next = salc_pkg::ST_SCAN;
            end
            salc_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = salc_pkg::ST_UPDATE;
                end
            end
            salc_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    if ((kind_reg == salc_pkg::KIND_MODIFY) && !second_reg)
                    begin
                        state_next = salc_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = salc_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = salc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready      = 1'b0;
        ram_re         = 1'b0;
        scan_ctl.start = 1'b0;
        scan_ctl.step  = 1'b0;
        upd_fire       = 1'b0;
        case (state_reg)
            salc_pkg::ST_IDLE:   req.ready = 1'b1;
            salc_pkg::ST_READ:
            begin
                ram_re         = 1'b1;
                scan_ctl.start = 1'b1;
            end
            salc_pkg::ST_SCAN:   scan_ctl.step = 1'b1;
            salc_pkg::ST_UPDATE: upd_fire = out_free;
            default:             ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= salc_pkg::ST_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                second_reg <= 1'b0;
            end
            else if (upd_fire)
            begin
                second_reg <= 1'b1;
            end
        end
    end

    // ---------------- tag store ----------------
    salc_ram #(
        .WIDTH (salc_pkg::ROW_W),
        .DEPTH (salc_pkg::NUM_SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (upd_fire),
        .waddr (set_reg),
        .wdata (row_new),
        .re    (ram_re),
        .raddr (set_reg),
        .rdata (ram_rdata)
    );

    // A set never written since reset reads as empty with all ranks zero.
    assign row_raw = salc_pkg::row_t'(ram_rdata);

    always_comb
    begin
        row_eff = row_raw;
        if (!row_ok_reg[set_reg])
        begin
            row_eff.valid = '0;
            row_eff.rank  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= '0;
        end
        else if (upd_fire)
        begin
            row_ok_reg[set_reg] <= 1'b1;
        end
    end

    salc_way_scan u_way_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .row      (row_eff),
        .tag      (tag_reg),
        .last_idx (last_idx),
        .done     (scan_done),
        .res      (scan_res)
    );

    // ---------------- row update ----------------
    assign is_fill  = !scan_res.hit && scan_res.free_found;
    assign is_evict = !scan_res.hit && !scan_res.free_found;

    always_comb
    begin
        if (scan_res.hit)
        begin
            way_sel  = scan_res.hit_way;
            old_rank = {1'b0, row_eff.rank[scan_res.hit_way]};
        end
        else if (is_fill)
        begin
            way_sel  = scan_res.free_way;
            old_rank = (salc_pkg::RANK_W + 1)'(salc_pkg::MAX_WAYS);
        end
        else
        begin
            way_sel  = scan_res.oldest_way;
            old_rank = {1'b0, scan_res.oldest_rank};
        end
    end

    always_comb
    begin
        valid_new          = row_eff.valid;
        valid_new[way_sel] = 1'b1;
    end

    salc_rank_update u_rank_update (
        .ranks_in  (row_eff.rank),
        .valid     (valid_new),
        .ways_eff  (ways_eff),
        .way       (way_sel),
        .old_rank  (old_rank),
        .ranks_out (ranks_new)
    );

    always_comb
    begin
        row_new       = row_eff;
        row_new.valid = valid_new;
        row_new.rank  = ranks_new;
        if (!scan_res.hit)
        begin
            row_new.tag[way_sel] = tag_reg;
        end
    end

    // ---------------- counters and result ----------------
    always_comb
    begin
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        evictions_next = evictions_reg;
        if (scan_res.hit)
        begin
            if (hits_reg != '1)
            begin
                hits_next = hits_reg + 1'b1;
            end
        end
        else if (misses_reg != '1)
        begin
            misses_next = misses_reg + 1'b1;
        end
        if (is_evict && (evictions_reg != '1))
        begin
            evictions_next = evictions_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg      <= '0;
            misses_reg    <= '0;
            evictions_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (upd_fire)
            begin
                hits_reg      <= hits_next;
                misses_reg    <= misses_next;
                evictions_reg <= evictions_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            out_hit_reg   <= scan_res.hit;
            out_evict_reg <= is_evict;
            out_way_reg   <= way_sel;
            out_last_reg  <= (kind_reg != salc_pkg::KIND_MODIFY) || second_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.was_hit        = out_hit_reg;
    assign rsp.was_eviction   = out_evict_reg;
    assign rsp.way_used       = out_way_reg;
    assign rsp.hit_total      = hits_reg;
    assign rsp.miss_total     = misses_reg;
    assign rsp.eviction_total = evictions_reg;
    assign rsp.last           = out_last_reg;

endmodule

// File: hw/rtl/salc_ram.sv
// ============================================================================
// salc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ============================================================================
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/salc_way_scan.sv
// ============================================================================
// salc_way_scan: shared way comparator
// Visits one way of the fetched row per cycle with a single tag comparator and
// tracks the first hit, the lowest free way and the oldest way.
// ============================================================================
module salc_way_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  salc_pkg::scan_ctl_t         ctl,
    input  salc_pkg::row_t              row,
    input  logic [salc_pkg::TAG_W-1:0]  tag,
    input  logic [salc_pkg::WAY_W-1:0]  last_idx,
    output logic                        done,
    output salc_pkg::scan_res_t         res
);

    logic [salc_pkg::WAY_W-1:0]  idx_reg;
    logic [salc_pkg::WAY_W-1:0]  idx_next;
    salc_pkg::scan_res_t         res_reg;
    salc_pkg::scan_res_t         res_next;
    logic                        way_valid;
    logic                        way_match;
    logic [salc_pkg::RANK_W-1:0] way_rank;
    logic                        first;

    assign way_valid = row.valid[idx_reg];
    assign way_match = way_valid && (row.tag[idx_reg] == tag);
    assign way_rank  = row.rank[idx_reg];
    assign first     = (idx_reg == '0);

    always_comb
    begin
        res_next = res_reg;
        idx_next = idx_reg;
        if (ctl.start)
        begin
            idx_next = '0;
        end
        else if (ctl.step)
        begin
            idx_next = idx_reg + 1'b1;
            if (first)
            begin
                res_next.hit         = way_match;
                res_next.hit_way     = idx_reg;
                res_next.free_found  = !way_valid;
                res_next.free_way    = idx_reg;
                res_next.oldest_rank = way_rank;
                res_next.oldest_way  = idx_reg;
            end
            else
            begin
                if (!res_reg.hit && way_match)
                begin
                    res_next.hit     = 1'b1;
                    res_next.hit_way = idx_reg;
                end
                if (!res_reg.free_found && !way_valid)
                begin
                    res_next.free_found = 1'b1;
                    res_next.free_way   = idx_reg;
                end
                // Ties keep the lower way, so only a strictly older rank wins.
                if (way_rank > res_reg.oldest_rank)
                begin
                    res_next.oldest_rank = way_rank;
                    res_next.oldest_way  = idx_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done = ctl.step && (way_match || (idx_reg == last_idx));
    assign res  = res_next;

endmodule

// File: hw/rtl/salc_rank_update.sv
// ============================================================================
// salc_rank_update: LRU rank update of one set
// Makes the chosen way most recently used and ages the valid ways in use that
// were younger than it, saturating at the oldest rank.
// ============================================================================
module salc_rank_update (
    input  salc_pkg::rank_vec_t           ranks_in,
    input  logic [salc_pkg::MAX_WAYS-1:0] valid,
    input  logic [salc_pkg::WCNT_W-1:0]   ways_eff,
    input  logic [salc_pkg::WAY_W-1:0]    way,
    input  logic [salc_pkg::RANK_W:0]     old_rank,
    output salc_pkg::rank_vec_t           ranks_out
);

    localparam logic [salc_pkg::RANK_W-1:0] RANK_MAX =
        salc_pkg::RANK_W'(salc_pkg::MAX_WAYS - 1);

    always_comb
    begin
        ranks_out = ranks_in;
        for (int i = 0; i < salc_pkg::MAX_WAYS; i++)
        begin
            if (salc_pkg::WAY_W'(i) == way)
            begin
                ranks_out[i] = '0;
            end
            else if ((salc_pkg::WCNT_W'(i) < ways_eff) && valid[i]
                     && ({1'b0, ranks_in[i]} < old_rank) && (ranks_in[i] < RANK_MAX))
            begin
                ranks_out[i] = ranks_in[i] + 1'b1;
            end
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench of the set-associative LRU lookup unit
// Drives cache accesses under several register settings, predicts hit, miss,
// eviction, way and counter totals per lookup and checks every result item.
// ============================================================================
module testbench;
    import salc_pkg::*;

    typedef struct {
        kind_t             kind;
        logic [ADDR_W-1:0] address;
    } access_t;

    typedef struct {
        bit               was_hit;
        bit               was_eviction;
        bit [WAY_W-1:0]   way_used;
        bit [CNT_W-1:0]   hit_total;
        bit [CNT_W-1:0]   miss_total;
        bit [CNT_W-1:0]   eviction_total;
        bit               last;
    } lookup_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    salc_req_if req_ch ();
    salc_rsp_if rsp_ch ();

    set_assoc_lru_cache_lookup_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Shadow copy of the cache state and registers.
    bit               line_valid [NUM_SETS*MAX_WAYS];
    logic [TAG_W-1:0] line_tag   [NUM_SETS*MAX_WAYS];
    bit [RANK_W-1:0]  line_rank  [NUM_SETS*MAX_WAYS];
    bit [CNT_W-1:0]   hit_count;
    bit [CNT_W-1:0]   miss_count;
    bit [CNT_W-1:0]   evict_count;
    bit [SB_W-1:0]    cfg_set_bits;
    bit [OB_W-1:0]    cfg_offset_bits;
    bit [3:0]         cfg_ways;

    access_t        pending_accesses [$];
    lookup_result_t expected_lookups [$];
    int             accesses_in_flight;
    int             mismatch_count;
    int             idle_odds;
    int             send_gap;
    int             recv_stall;
    bit             req_taken;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned eff_set_bits();
        return (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
    endfunction

    function automatic int unsigned eff_ways();
        if (cfg_ways == 0)
            return 1;
        return (cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways;
    endfunction

    function automatic bit [CNT_W-1:0] bump(bit [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Make way w most recently used; younger valid ways with a rank below the
    // one it held move back by one, up to the oldest rank.
    function automatic void promote_way(int unsigned base, int unsigned ways,
                                        int unsigned w, int unsigned old_rank);
        int unsigned k;
        for (int unsigned i = 0; i < ways; i++)
        begin
            k = base + i;
            if (i != w && line_valid[k] && line_rank[k] < old_rank
                && line_rank[k] < MAX_WAYS - 1)
                line_rank[k] = line_rank[k] + 1'b1;
        end
        line_rank[base + w] = '0;
    endfunction

    function automatic lookup_result_t run_lookup(logic [ADDR_W-1:0] addr, bit is_last);
        int unsigned    sb;
        int unsigned    ob;
        int unsigned    ways;
        int unsigned    base;
        int unsigned    w;
        int unsigned    oldest;
        logic [TAG_W-1:0] tag;
        bit             found;
        lookup_result_t r;
        sb = eff_set_bits();
        ob = cfg_offset_bits;
        ways = eff_ways();
        tag = addr >> (ob + sb);
        base = int'((addr >> ob) & ((64'd1 << sb) - 1)) * MAX_WAYS;
        found = 1'b0;
        w = 0;
        r = '{default: 0};
        for (int unsigned i = 0; i < ways && !found; i++)
        begin
            if (line_valid[base + i] && line_tag[base + i] == tag)
            begin
                found = 1'b1;
                w = i;
            end
        end
        if (found)
        begin
            r.was_hit = 1'b1;
            hit_count = bump(hit_count);
            promote_way(base, ways, w, line_rank[base + w]);
        end
        else
        begin
            miss_count = bump(miss_count);
            for (int unsigned i = 0; i < ways && !found; i++)
            begin
                if (!line_valid[base + i])
                begin
                    found = 1'b1;
                    w = i;
                end
            end
            if (found)
            begin
                line_valid[base + w] = 1'b1;
                line_tag[base + w] = tag;
                promote_way(base, ways, w, MAX_WAYS);
            end
            else
            begin
                // Every way in use is valid: replace the oldest, lowest on a tie.
                r.was_eviction = 1'b1;
                evict_count = bump(evict_count);
                oldest = 0;
                for (int unsigned i = 0; i < ways; i++)
                begin
                    if (i == 0 || line_rank[base + i] > oldest)
                    begin
                        oldest = line_rank[base + i];
                        w = i;
                    end
                end
                line_tag[base + w] = tag;
                promote_way(base, ways, w, oldest);
            end
        end
        r.way_used = w[WAY_W-1:0];
        r.hit_total = hit_count;
        r.miss_total = miss_count;
        r.eviction_total = evict_count;
        r.last = is_last;
        return r;
    endfunction

    function automatic void predict_access(kind_t kind, logic [ADDR_W-1:0] addr);
        case (kind)
            KIND_IFETCH: ;
            KIND_MODIFY:
            begin
                expected_lookups.push_back(run_lookup(addr, 1'b0));
                expected_lookups.push_back(run_lookup(addr, 1'b1));
            end
            default: expected_lookups.push_back(run_lookup(addr, 1'b1));
        endcase
    endfunction

    function automatic void add_access(kind_t kind, logic [ADDR_W-1:0] addr);
        access_t a;
        a.kind = kind;
        a.address = addr;
        pending_accesses.push_back(a);
        accesses_in_flight++;
    endfunction

    // Builds an address from a tag and a set under the current split.
    function automatic logic [ADDR_W-1:0] cache_address(logic [TAG_W-1:0] tag,
                                                         int unsigned set_idx);
        int unsigned       sb;
        int unsigned       ob;
        logic [ADDR_W-1:0] offs;
        sb = eff_set_bits();
        ob = cfg_offset_bits;
        offs = {$urandom, $urandom} & ((64'd1 << ob) - 1);
        return (tag << (ob + sb)) | (64'(set_idx) << ob) | offs;
    endfunction

    task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    endtask

    task automatic wait_drained();
        while (accesses_in_flight != 0 || expected_lookups.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_SET_BITS:    cfg_set_bits = value[SB_W-1:0];
            CFG_OFFSET_BITS: cfg_offset_bits = value[OB_W-1:0];
            CFG_WAYS_IN_USE: cfg_ways = value[3:0];
            default: ;
        endcase
    endtask

    // Registers change only once the unit has gone quiet.
    task automatic apply_config(logic [CFG_DATA_W-1:0] sb, logic [CFG_DATA_W-1:0] ob,
                                logic [CFG_DATA_W-1:0] ways, bit poke_unused);
        wait_drained();
        repeat (30) @(negedge clk);
        write_reg(CFG_SET_BITS, sb);
        write_reg(CFG_OFFSET_BITS, ob);
        write_reg(CFG_WAYS_IN_USE, ways);
        if (poke_unused)
            write_reg(CFG_UNUSED, 6'h3F);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_ways(logic [CFG_DATA_W-1:0] ways);
        wait_drained();
        repeat (30) @(negedge clk);
        write_reg(CFG_WAYS_IN_USE, ways);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Request acceptance: predict the results of the item just taken.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            predict_access(kind_t'(req_ch.kind), req_ch.address);
            accesses_in_flight--;
            req_taken = 1'b1;
        end
    end

    // Request driver.
    always @(negedge clk)
    begin
        access_t a;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_taken)
        begin
            req_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_accesses.size() > 0)
            begin
                a = pending_accesses.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.kind <= a.kind;
                req_ch.address <= a.address;
                if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                    send_gap = $urandom_range(1, 16);
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Result ready with random stall bursts.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (recv_stall > 0)
        begin
            recv_stall--;
            rsp_ch.ready <= 1'b0;
        end
        else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            recv_stall = $urandom_range(0, 15);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Result monitor.
    always @(posedge clk)
    begin
        lookup_result_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_lookups.size() == 0)
                flag_mismatch("result with none pending, miss_total", 0, rsp_ch.miss_total);
            else
            begin
                e = expected_lookups.pop_front();
                if (rsp_ch.was_hit !== e.was_hit)
                    flag_mismatch("was_hit", e.was_hit, rsp_ch.was_hit);
                if (rsp_ch.was_eviction !== e.was_eviction)
                    flag_mismatch("was_eviction", e.was_eviction, rsp_ch.was_eviction);
                if (rsp_ch.way_used !== e.way_used)
                    flag_mismatch("way_used", e.way_used, rsp_ch.way_used);
                if (rsp_ch.hit_total !== e.hit_total)
                    flag_mismatch("hit_total", e.hit_total, rsp_ch.hit_total);
                if (rsp_ch.miss_total !== e.miss_total)
                    flag_mismatch("miss_total", e.miss_total, rsp_ch.miss_total);
                if (rsp_ch.eviction_total !== e.eviction_total)
                    flag_mismatch("eviction_total", e.eviction_total, rsp_ch.eviction_total);
                if (rsp_ch.last !== e.last)
                    flag_mismatch("last", e.last, rsp_ch.last);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [TAG_W-1:0]  tag_pool [12];
        int unsigned       set_pool [3];
        int unsigned       corner_sb [4];
        int unsigned       corner_ob [4];
        int unsigned       corner_ways [4];
        int unsigned       sb_w;
        int unsigned       ob_w;
        int unsigned       ways_w;
        int unsigned       sent;
        int unsigned       tag_span;
        kind_t             kind;
        logic [ADDR_W-1:0] addr;

        corner_sb = '{63, 0, 6, 3};
        corner_ob = '{57, 0, 63, 58};
        corner_ways = '{63, 1, 8, 0};
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.kind = '0;
        req_ch.address = '0;
        rsp_ch.ready = 1'b0;
        cfg_set_bits = '0;
        cfg_offset_bits = '0;
        cfg_ways = 4'd1;
        hit_count = '0;
        miss_count = '0;
        evict_count = '0;
        accesses_in_flight = 0;
        mismatch_count = 0;
        send_gap = 0;
        recv_stall = 0;
        req_taken = 1'b0;
        idle_odds = 6;
        foreach (line_valid[i])
        begin
            line_valid[i] = 1'b0;
            line_rank[i] = '0;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Two sets of two ways: fill, hit, a modify, then LRU evictions.
        apply_config(6'd1, 6'd2, 6'd2, 1'b1);
        add_access(KIND_IFETCH, 64'h0);
        add_access(KIND_LOAD, 64'h0);
        add_access(KIND_STORE, 64'h0);
        add_access(KIND_MODIFY, '1);
        add_access(KIND_LOAD, 64'h8);
        add_access(KIND_LOAD, 64'h10);
        add_access(KIND_LOAD, 64'h0);
        add_access(KIND_IFETCH, '1);

        // Oversized set bits and ways; offset plus set bits reach 64, tag is 0.
        apply_config(6'd7, 6'd58, 6'd15, 1'b0);
        add_access(KIND_LOAD, 64'hFC00_0000_0000_0000);
        add_access(KIND_MODIFY, '1);
        add_access(KIND_LOAD, 64'h0400_0000_0000_0000);

        // Offset of 63 bits, and zero ways acting as one.
        apply_config(6'd0, 6'd63, 6'd0, 1'b0);
        add_access(KIND_LOAD, 64'h8000_0000_0000_0000);
        add_access(KIND_LOAD, 64'h0);
        add_access(KIND_STORE, 64'h8000_0000_0000_0000);

        // Shrinking the ways leaves a stale copy, so two valid ways match.
        apply_config(6'd6, 6'd0, 6'd2, 1'b0);
        add_access(KIND_LOAD, 64'h45);
        add_access(KIND_LOAD, 64'h85);
        set_ways(6'd1);
        add_access(KIND_LOAD, 64'h85);
        set_ways(6'd2);
        add_access(KIND_LOAD, 64'h85);

        for (int p = 0; p < 12; p++)
        begin
            if (p < 4)
            begin
                sb_w = corner_sb[p];
                ob_w = corner_ob[p];
                ways_w = corner_ways[p];
            end
            else
            begin
                sb_w = $urandom_range(0, 7);
                case ($urandom_range(0, 3))
                    0: ob_w = 0;
                    1: ob_w = $urandom_range(0, 20);
                    2: ob_w = $urandom_range(50, 63);
                    default: ob_w = $urandom_range(0, 63);
                endcase
                ways_w = $urandom_range(0, 15);
            end
            apply_config(sb_w[CFG_DATA_W-1:0], ob_w[CFG_DATA_W-1:0],
                         ways_w[CFG_DATA_W-1:0], p == 4);

            // The last phase runs with both sides at full rate.
            case ($urandom_range(0, 3))
                0: idle_odds = 0;
                1: idle_odds = 3;
                2: idle_odds = 8;
                default: idle_odds = 24;
            endcase
            if (p == 11)
                idle_odds = 0;

            // A few tags over a few sets keep the sets busy with hits and evictions.
            foreach (tag_pool[i])
                tag_pool[i] = (i % 2) ? {$urandom, $urandom} : 64'($urandom_range(0, 15));
            foreach (set_pool[i])
                set_pool[i] = $urandom_range(0, (1 << eff_set_bits()) - 1);
            tag_span = eff_ways() + 2;

            sent = 0;
            while (sent < 150)
            begin
                if (sent == 75)
                    wait_drained();
                kind = ($urandom_range(0, 9) == 0) ? KIND_IFETCH
                                                   : kind_t'($urandom_range(1, 3));
                if ($urandom_range(0, 7) == 0)
                    addr = {$urandom, $urandom};
                else
                    addr = cache_address(tag_pool[$urandom_range(0, tag_span)],
                                         set_pool[$urandom_range(0, 2)]);
                add_access(kind, addr);
                if (kind != KIND_IFETCH)
                    sent++;
            end
        end

        wait_drained();
        repeat (40) @(negedge clk);
        if (expected_lookups.size() != 0)
            $display("%0d expected results never arrived", expected_lookups.size());
        if (mismatch_count == 0 && expected_lookups.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
